### design/s2cd_pkg.sv
// Shared types, constants and tables of the seconds to calendar date converter.
package s2cd_pkg;

   // Field widths
   localparam int WS_W    = 40;
   localparam int US_W    = 20;
   localparam int OFF_W   = 39;
   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   // Number of pipeline stages, the output register included
   localparam int NUM_STAGES = 9;

   // Epoch offset after reset: the Unix epoch counted from Julian day zero noon
   localparam logic [OFF_W-1:0] EPOCH_RESET = 39'd210866760000;

   // Rounding threshold for the microsecond fraction
   localparam logic [US_W-1:0] HALF_SECOND_US = 20'd500000;

   // The time is biased by a whole number of days so that it is never negative
   localparam longint BIAS_DAYS  = 6400000;
   localparam longint GREG_CYCLE = 146097;
   localparam logic [40:0] V_BIAS = 41'(BIAS_DAYS * 86400 + 43200);

   // Day thresholds in the biased day count
   localparam logic [24:0] GREG_DAYP = 25'(BIAS_DAYS + 2299161);
   localparam logic [24:0] BC_DAYP   = 25'(BIAS_DAYS + 1721424);

   // Start days of the 400-year cycle counts, one cycle early so counts stay positive
   localparam logic [24:0] CYC_BASE_A = 25'(BIAS_DAYS + 2342032 - GREG_CYCLE);
   localparam logic [24:0] CYC_BASE_B = 25'(BIAS_DAYS + 2378556 - GREG_CYCLE);
   localparam logic [24:0] CYC_BASE_C = 25'(BIAS_DAYS + 2415080 - GREG_CYCLE);
   localparam logic [8:0]  GREG_SHIFT = 9'd10;

   // Day count shifted by whole 4-year groups so the year split works unsigned
   localparam longint JQ_R = (BIAS_DAYS - 32083) / 1461 + 1;
   localparam logic [24:0] JQ_OFF   = 25'(32083 + 1461 * JQ_R - BIAS_DAYS);
   localparam logic [15:0] YEAR_OFF = 16'(4 * JQ_R + 4800);
   localparam logic [26:0] DAYS_PER_4Y = 27'd1461;

   // Time of day constants
   localparam logic [16:0] SEC_PER_DAY_LO = 17'd86400;
   localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
   localparam logic [11:0] SEC_PER_MIN    = 12'd60;

   // Reciprocals: floor(n / d) = (n * ceil(2^s / d)) >> s for n below 2^(s - ceil(log2 d))
   localparam longint ONE = 1;
   localparam int R675_S    = 44;
   localparam logic [34:0] R675 = 35'(((ONE << R675_S) + 674) / 675);
   localparam int R146097_S = 43;
   localparam logic [25:0] R146097 = 26'(((ONE << R146097_S) + 146096) / 146097);
   localparam int R1461_S   = 38;
   localparam logic [27:0] R1461 = 28'(((ONE << R1461_S) + 1460) / 1461);
   localparam int R306_S    = 21;
   localparam logic [12:0] R306 = 13'(((ONE << R306_S) + 305) / 306);
   localparam int R3600_S   = 29;
   localparam logic [17:0] R3600 = 18'(((ONE << R3600_S) + 3599) / 3600);
   localparam int R60_S     = 18;
   localparam logic [12:0] R60 = 13'(((ONE << R60_S) + 59) / 60);

   // Pipeline control between the stage sequencer and the datapath
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // Days from March 1 to the first day of the k-th month counted from March
   function automatic logic [8:0] month_start_day(input logic [3:0] k);
      logic [8:0] days;
      case (k)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

### design/s2cd_req_if.sv
// Request channel: whole seconds and microsecond fraction with valid/ready.
interface s2cd_req_if;
   import s2cd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [WS_W-1:0] whole_seconds;
   logic [US_W-1:0]        micro_seconds;

   modport source (output valid, whole_seconds, micro_seconds, input ready);
   modport sink   (input valid, whole_seconds, micro_seconds, output ready);
endinterface

### design/s2cd_rsp_if.sv
// Response channel: calendar date and time of day with valid/ready.
interface s2cd_rsp_if;
   import s2cd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [YEAR_W-1:0] year;
   logic [MONTH_W-1:0]       month;
   logic [DOM_W-1:0]         day_of_month;
   logic [HOUR_W-1:0]        hour;
   logic [MIN_W-1:0]         minute;
   logic [SEC_W-1:0]         second;

   modport source (output valid, year, month, day_of_month, hour, minute, second,
                   input ready);
   modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                   output ready);
endinterface

### design/s2cd_pipe_ctrl.sv
// Valid bits and per-stage load enables of the conversion pipeline.
module s2cd_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    out_ready,
   output s2cd_pkg::pipe_ctrl_type pipe
);
   import s2cd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // A stage loads when it is empty or its content moves on
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // Valid bits follow the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign pipe.load  = load;
   assign pipe.valid = valid_ff;

endmodule

### design/seconds_to_calendar_date.sv
// Seconds to calendar date: nine-stage pipeline, one request per cycle unless stalled.
//
// Each request carries signed whole seconds and a microsecond fraction. The
// offset register (csr_write_data, written when csr_write_enable is high;
// 210866760000 after reset, the Unix epoch in seconds from Julian day zero
// noon; 0 counts directly from that point) is added, and the response gives
// year, month, day, hour, minute and second. Dates before 1582-10-15 are
// Julian, later ones Gregorian; 1 BC is year -1. The second is rounded half
// up, so 23:59:59.5 or later shows as hour 24, minute 0 of the same date.
// A request moves through stages 1 to 9, the last of which is the response
// register; a new request is accepted every cycle as long as responses are
// taken, and a stalled response holds the pipeline behind it stage by stage.
// The pipeline depth comes from the chain of constant-reciprocal multipliers
// (day, 400-year cycle, 4-year group, month, hour, minute), each followed by
// a register.
module seconds_to_calendar_date (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [s2cd_pkg::OFF_W-1:0]  csr_write_data,
   s2cd_req_if.sink                    req_if,
   s2cd_rsp_if.source                  rsp_if
);
   import s2cd_pkg::*;

   pipe_ctrl_type pipe;

   logic [OFF_W-1:0] epoch_ff;

   logic [40:0] s1_v_in, s1_v_ff;
   logic        s1_rnd_in, s1_rnd_ff;

   logic [33:0] s2_x;
   logic [51:0] s2_ph_in, s2_ph_ff, s2_pl_in, s2_pl_ff;
   logic [16:0] s2_vlo_ff;
   logic        s2_rnd_ff;

   logic [68:0] s3_sum;
   logic [24:0] s3_dayp_in, s3_dayp_ff;
   logic [16:0] s3_vlo_ff;
   logic        s3_rnd_ff;

   logic [16:0] s4_day_secs;
   logic [16:0] s4_rs_in, s4_rs_ff;
   logic        s4_greg_in, s4_greg_ff, s4_bc_in, s4_bc_ff;
   logic [24:0] s4_na, s4_nb, s4_nc;
   logic [50:0] s4_pa_in, s4_pa_ff, s4_pb_in, s4_pb_ff, s4_pc_in, s4_pc_ff;
   logic [24:0] s4_dayp_ff;

   logic [8:0]  s5_corr;
   logic [24:0] s5_jq_in, s5_jq_ff;
   logic [34:0] s5_hprod_in, s5_hprod_ff;
   logic [16:0] s5_rs_ff;
   logic        s5_bc_ff;

   logic [26:0] s6_n4;
   logic [54:0] s6_yprod_in, s6_yprod_ff;
   logic [4:0]  s6_hr_in, s6_hr_ff;
   logic [16:0] s6_hr_secs;
   logic [11:0] s6_rem_in, s6_rem_ff;
   logic [24:0] s6_jq_ff;
   logic        s6_bc_ff;

   logic [16:0] s7_yq_in, s7_yq_ff;
   logic [26:0] s7_ydays;
   logic [8:0]  s7_dom_in, s7_dom_ff;
   logic [24:0] s7_mnprod_in, s7_mnprod_ff;
   logic [4:0]  s7_hr_ff;
   logic [11:0] s7_rem_ff;
   logic        s7_bc_ff;

   logic [11:0] s8_t;
   logic [24:0] s8_mprod_in, s8_mprod_ff;
   logic [5:0]  s8_mn_in, s8_mn_ff;
   logic [5:0]  s8_sec_in, s8_sec_ff;
   logic [16:0] s8_yq_ff;
   logic [8:0]  s8_dom_ff;
   logic [4:0]  s8_hr_ff;
   logic        s8_bc_ff;

   logic [3:0]  s9_k;
   logic        s9_wrap;
   logic [15:0] s9_year_in, s9_year_ff;
   logic [3:0]  s9_month_in, s9_month_ff;
   logic [4:0]  s9_dom_in, s9_dom_ff;
   logic [4:0]  s9_hr_ff;
   logic [5:0]  s9_mn_ff, s9_sec_ff;

   // Stage sequencing
   s2cd_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .pipe      (pipe)
   );

   assign req_if.ready = pipe.load[0];

   // Epoch offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_RESET;
      end else if (csr_write_enable) begin
         epoch_ff <= csr_write_data;
      end
   end

   // Stage 1: biased seconds since midnight before Julian day zero
   always_comb begin
      s1_v_in   = 41'(req_if.whole_seconds) + 41'(epoch_ff) + V_BIAS;
      s1_rnd_in = req_if.micro_seconds >= HALF_SECOND_US;
   end

   always_ff @(posedge clock) begin
      if (pipe.load[0]) begin
         s1_v_ff   <= s1_v_in;
         s1_rnd_ff <= s1_rnd_in;
      end
   end

   // Stage 2: day number as (v / 128) / 675, two partial products
   always_comb begin
      s2_x     = s1_v_ff[40:7];
      s2_ph_in = 52'(s2_x[33:17]) * 52'(R675);
      s2_pl_in = 52'(s2_x[16:0]) * 52'(R675);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[1]) begin
         s2_ph_ff  <= s2_ph_in;
         s2_pl_ff  <= s2_pl_in;
         s2_vlo_ff <= s1_v_ff[16:0];
         s2_rnd_ff <= s1_rnd_ff;
      end
   end

   // Stage 3: combine partial products
   always_comb begin
      s3_sum     = {s2_ph_ff, 17'd0} + 69'(s2_pl_ff);
      s3_dayp_in = s3_sum[68:R675_S];
   end

   always_ff @(posedge clock) begin
      if (pipe.load[2]) begin
         s3_dayp_ff <= s3_dayp_in;
         s3_vlo_ff  <= s2_vlo_ff;
         s3_rnd_ff  <= s2_rnd_ff;
      end
   end

   // Stage 4: rounded second of day, calendar flags, 400-year cycle counts
   always_comb begin
      s4_day_secs = 17'(s3_dayp_ff[16:0] * SEC_PER_DAY_LO);
      s4_rs_in    = s3_vlo_ff - s4_day_secs + 17'(s3_rnd_ff);
      s4_greg_in  = s3_dayp_ff >= GREG_DAYP;
      s4_bc_in    = s3_dayp_ff < BC_DAYP;
      s4_na       = s3_dayp_ff - CYC_BASE_A;
      s4_nb       = s3_dayp_ff - CYC_BASE_B;
      s4_nc       = s3_dayp_ff - CYC_BASE_C;
      s4_pa_in    = 51'(s4_na) * 51'(R146097);
      s4_pb_in    = 51'(s4_nb) * 51'(R146097);
      s4_pc_in    = 51'(s4_nc) * 51'(R146097);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[3]) begin
         s4_rs_ff   <= s4_rs_in;
         s4_greg_ff <= s4_greg_in;
         s4_bc_ff   <= s4_bc_in;
         s4_pa_ff   <= s4_pa_in;
         s4_pb_ff   <= s4_pb_in;
         s4_pc_ff   <= s4_pc_in;
         s4_dayp_ff <= s3_dayp_ff;
      end
   end

   // Stage 5: Gregorian correction, shifted day count, hour product
   always_comb begin
      if (s4_greg_ff) begin
         s5_corr = 9'(s4_pa_ff[50:R146097_S]) + 9'(s4_pb_ff[50:R146097_S])
                 + 9'(s4_pc_ff[50:R146097_S]) + GREG_SHIFT;
      end else begin
         s5_corr = 9'd0;
      end
      s5_jq_in    = s4_dayp_ff + 25'(s5_corr) + JQ_OFF;
      s5_hprod_in = 35'(s4_rs_ff) * 35'(R3600);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[4]) begin
         s5_jq_ff    <= s5_jq_in;
         s5_hprod_ff <= s5_hprod_in;
         s5_rs_ff    <= s4_rs_ff;
         s5_bc_ff    <= s4_bc_ff;
      end
   end

   // Stage 6: 4-year group product, hour and remaining seconds
   always_comb begin
      s6_n4       = {s5_jq_ff, 2'b00} - 27'd1;
      s6_yprod_in = 55'(s6_n4) * 55'(R1461);
      s6_hr_in    = s5_hprod_ff[33:R3600_S];
      s6_hr_secs  = 17'(s6_hr_in) * SEC_PER_HOUR;
      s6_rem_in   = 12'(s5_rs_ff - s6_hr_secs);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[5]) begin
         s6_yprod_ff <= s6_yprod_in;
         s6_hr_ff    <= s6_hr_in;
         s6_rem_ff   <= s6_rem_in;
         s6_jq_ff    <= s5_jq_ff;
         s6_bc_ff    <= s5_bc_ff;
      end
   end

   // Stage 7: year from March, day within that year, minute product
   always_comb begin
      s7_yq_in     = s6_yprod_ff[54:R1461_S];
      s7_ydays     = 27'(s7_yq_in) * DAYS_PER_4Y;
      s7_dom_in    = 9'(s6_jq_ff - 25'(s7_ydays[26:2]));
      s7_mnprod_in = 25'(s6_rem_ff) * 25'(R60);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[6]) begin
         s7_yq_ff     <= s7_yq_in;
         s7_dom_ff    <= s7_dom_in;
         s7_mnprod_ff <= s7_mnprod_in;
         s7_hr_ff     <= s6_hr_ff;
         s7_rem_ff    <= s6_rem_ff;
         s7_bc_ff     <= s6_bc_ff;
      end
   end

   // Stage 8: month product, minute and second
   always_comb begin
      s8_t        = 12'(s7_dom_ff) * 12'd10 - 12'd6;
      s8_mprod_in = 25'(s8_t) * 25'(R306);
      s8_mn_in    = s7_mnprod_ff[23:R60_S];
      s8_sec_in   = 6'(s7_rem_ff - 12'(s8_mn_in) * SEC_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[7]) begin
         s8_mprod_ff <= s8_mprod_in;
         s8_mn_ff    <= s8_mn_in;
         s8_sec_ff   <= s8_sec_in;
         s8_yq_ff    <= s7_yq_ff;
         s8_dom_ff   <= s7_dom_ff;
         s8_hr_ff    <= s7_hr_ff;
         s8_bc_ff    <= s7_bc_ff;
      end
   end

   // Stage 9: month, day of month, year with January/February wrap and BC shift
   always_comb begin
      s9_k      = s8_mprod_ff[24:R306_S];
      s9_wrap   = s9_k >= 4'd10;
      s9_dom_in = 5'(s8_dom_ff - month_start_day(s9_k));
      if (s9_wrap) begin
         s9_month_in = s9_k - 4'd9;
      end else begin
         s9_month_in = s9_k + 4'd3;
      end
      s9_year_in = 16'(s8_yq_ff) - YEAR_OFF + 16'(s9_wrap) - 16'(s8_bc_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe.load[8]) begin
         s9_year_ff  <= s9_year_in;
         s9_month_ff <= s9_month_in;
         s9_dom_ff   <= s9_dom_in;
         s9_hr_ff    <= s8_hr_ff;
         s9_mn_ff    <= s8_mn_ff;
         s9_sec_ff   <= s8_sec_ff;
      end
   end

   // Response
   assign rsp_if.valid        = pipe.valid[NUM_STAGES-1];
   assign rsp_if.year         = s9_year_ff;
   assign rsp_if.month        = s9_month_ff;
   assign rsp_if.day_of_month = s9_dom_ff;
   assign rsp_if.hour         = s9_hr_ff;
   assign rsp_if.minute       = s9_mn_ff;
   assign rsp_if.second       = s9_sec_ff;

   // Checks on the produced date and time
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.month >= 4'd1 && rsp_if.month <= 4'd12))
      else $error("month out of range");

   a_dom_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.day_of_month >= 5'd1 && rsp_if.day_of_month <= 5'd31))
      else $error("day of month out of range");

   a_hour_24: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.hour >= 5'd24) |->
         (rsp_if.hour == 5'd24 && rsp_if.minute == 6'd0 && rsp_if.second == 6'd0))
      else $error("hour 24 without midnight");

   a_min_sec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.minute <= 6'd59 && rsp_if.second <= 6'd59))
      else $error("minute or second out of range");

endmodule

### sim/calendar_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the calendar date converter, predicts each response and compares it.
module calendar_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [s2cd_pkg::OFF_W-1:0] csr_write_data,
   s2cd_req_if                        req_mon,
   s2cd_rsp_if                        rsp_mon,
   output int                         fail_count,
   output int                         pending
);
   import s2cd_pkg::*;

   localparam longint DAY_SECONDS   = 86400;
   localparam longint CYCLE_SECONDS = 146097 * DAY_SECONDS;

   typedef struct {
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [DOM_W-1:0]         day_of_month;
      logic [HOUR_W-1:0]        hour;
      logic [MIN_W-1:0]         minute;
      logic [SEC_W-1:0]         second;
   } calendar_type;

   calendar_type     expected_dates[$];
   logic [OFF_W-1:0] epoch_offset = EPOCH_RESET;
   int               mismatches   = 0;
   int               waiting      = 0;
   int               responses    = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // True floor, also for negative numerators
   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // Number of 400-year cycles begun since a given start day
   function automatic longint cycles_from(longint u, longint start_day);
      return floor_div(u - start_day * DAY_SECONDS, CYCLE_SECONDS) + 1;
   endfunction

   // Calendar date and rounded time of day for one request
   function automatic calendar_type to_calendar(logic signed [WS_W-1:0] ws,
                                                logic [US_W-1:0] us,
                                                logic [OFF_W-1:0] offset);
      calendar_type c;
      longint       u, day, sod, j, y0, dom, mon, year, rs, hr, mn, micros;
      logic         bc;
      micros = (us > 20'd999999) ? 64'd999999 : longint'(us);
      u      = longint'(ws) + longint'(offset) + 43200;
      bc     = (u < 1721424 * DAY_SECONDS);
      day    = floor_div(u, DAY_SECONDS);
      sod    = u - day * DAY_SECONDS;
      // Gregorian correction after the 1582 reform
      if (u >= 2299161 * DAY_SECONDS) begin
         day = day + cycles_from(u, 2342032) + cycles_from(u, 2378556) +
               cycles_from(u, 2415080) + 10;
      end
      j    = day + 32083;
      y0   = -floor_div(-4 * j, 1461) - 1;
      year = y0 - 4800;
      dom  = j - floor_div(y0 * 1461, 4);
      mon  = floor_div(10 * dom - 6, 306) + 3;
      dom  = dom - floor_div(306 * (mon - 3) + 5, 10);
      if (mon > 12) begin
         mon  = mon - 12;
         year = year + 1;
      end
      if (bc) year = year - 1;
      // Time of day, second rounded half up
      rs = sod + ((micros >= 500000) ? 1 : 0);
      hr = rs / 3600;
      rs = rs - hr * 3600;
      mn = rs / 60;
      rs = rs - mn * 60;
      c.year         = YEAR_W'(year);
      c.month        = MONTH_W'(mon);
      c.day_of_month = DOM_W'(dom);
      c.hour         = HOUR_W'(hr);
      c.minute       = MIN_W'(mn);
      c.second       = SEC_W'(rs);
      return c;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Track requests, responses and offset writes
   always @(posedge clock) begin
      calendar_type want, got;
      if (reset) begin
         epoch_offset = EPOCH_RESET;
         expected_dates.delete();
         waiting = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.year         = rsp_mon.year;
            got.month        = rsp_mon.month;
            got.day_of_month = rsp_mon.day_of_month;
            got.hour         = rsp_mon.hour;
            got.minute       = rsp_mon.minute;
            got.second       = rsp_mon.second;
            if (expected_dates.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_dates.pop_front();
               if (got.year !== want.year)
                  report_mismatch($sformatf("response %0d year %0d, expected %0d",
                                            responses, got.year, want.year));
               if (got.month !== want.month)
                  report_mismatch($sformatf("response %0d month %0d, expected %0d",
                                            responses, got.month, want.month));
               if (got.day_of_month !== want.day_of_month)
                  report_mismatch($sformatf("response %0d day %0d, expected %0d",
                                            responses, got.day_of_month, want.day_of_month));
               if (got.hour !== want.hour)
                  report_mismatch($sformatf("response %0d hour %0d, expected %0d",
                                            responses, got.hour, want.hour));
               if (got.minute !== want.minute)
                  report_mismatch($sformatf("response %0d minute %0d, expected %0d",
                                            responses, got.minute, want.minute));
               if (got.second !== want.second)
                  report_mismatch($sformatf("response %0d second %0d, expected %0d",
                                            responses, got.second, want.second));
            end
            responses++;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_dates.insert(expected_dates.size(),
                                  to_calendar(req_mon.whole_seconds, req_mon.micro_seconds,
                                              epoch_offset));
         end
         if (csr_write_enable) epoch_offset = csr_write_data;
         waiting = expected_dates.size();
      end
   end

endmodule

### sim/seconds_to_calendar_date_test.sv
`timescale 1ns / 1ps
// Top of the calendar date converter testbench: clock, reset, stimulus, receiver and verdict.
module seconds_to_calendar_date_test;
   import s2cd_pkg::*;

   localparam longint DAY_SECONDS = 86400;
   localparam int     STALL_LIMIT = 1000;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [OFF_W-1:0] csr_write_data   = '0;

   logic [OFF_W-1:0] epoch_now   = EPOCH_RESET;
   int               burst_left  = 0;
   int               quiet_cycles = 0;
   int               fail_count;
   int               pending;

   s2cd_req_if req_ch ();
   s2cd_rsp_if rsp_ch ();

   seconds_to_calendar_date i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch)
   );

   calendar_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Day numbers where the calendar rules change
   function automatic longint key_day(int k);
      longint d;
      case (k)
         0:       d = 0;
         1:       d = 1721424;
         2:       d = 2299161;
         3:       d = 2342032;
         4:       d = 2378556;
         5:       d = 2415080;
         default: d = 2440588;
      endcase
      return d;
   endfunction

   function automatic logic [WS_W-1:0] rand_word40();
      return {8'($urandom), $urandom};
   endfunction

   // Whole seconds that land on a given count from midnight before day zero
   function automatic logic [WS_W-1:0] ws_for(longint u);
      return WS_W'(u - 43200 - longint'(epoch_now));
   endfunction

   // Offer one request, in bursts with random gaps
   task automatic send_request(input logic [WS_W-1:0] ws, input logic [US_W-1:0] us);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid         <= 1'b0;
            req_ch.whole_seconds <= rand_word40();
            req_ch.micro_seconds <= US_W'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid         <= 1'b1;
      req_ch.whole_seconds <= ws;
      req_ch.micro_seconds <= us;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Random request: full range, near rule changes, plausible dates, ends of day
   task automatic send_random();
      longint            u;
      logic [WS_W-1:0]   ws;
      logic [US_W-1:0]   us;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         ws = rand_word40();
      end else if (pick < 55) begin
         u  = key_day($urandom_range(0, 6)) * DAY_SECONDS +
              longint'($urandom_range(0, 6 * 86400)) - 3 * DAY_SECONDS;
         ws = ws_for(u);
      end else if (pick < 80) begin
         u  = longint'($urandom_range(0, 4000000)) * DAY_SECONDS +
              longint'($urandom_range(0, 86399));
         ws = ws_for(u);
      end else begin
         u  = longint'($urandom_range(0, 4000000)) * DAY_SECONDS +
              longint'(($urandom_range(0, 2) == 0) ? $urandom_range(86390, 86399) : 86399);
         ws = ws_for(u);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      us = US_W'($urandom_range(0, 999999));
      else if (pick < 60) us = US_W'(499998 + $urandom_range(0, 4));
      else if (pick < 70) us = US_W'($urandom_range(999999, 1048575));
      else if (pick < 80) us = '0;
      else                us = US_W'($urandom);
      send_request(ws, us);
   endtask

   // Stop offering and let every outstanding response come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (NUM_STAGES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OFF_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      epoch_now = value;
   endtask

   // Receiver: stall pattern of its own, plus a long hold-off now and then
   initial begin
      logic [15:0] stall_pattern;
      int          pattern_age;
      int          hold_left;
      int          rsp_taken;
      stall_pattern = '1;
      pattern_age   = 0;
      hold_left     = 0;
      rsp_taken     = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken++;
            if (rsp_taken % 300 == 150) hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pattern = '1;
                  1:       stall_pattern = 16'($urandom);
                  2:       stall_pattern = 16'($urandom) | 16'($urandom);
                  default: stall_pattern = 16'($urandom) & 16'($urandom);
               endcase
               pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            rsp_ch.ready <= stall_pattern[0];
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[seconds_to_calendar_date] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      logic [OFF_W-1:0] next_offset;
      req_ch.valid         <= 1'b0;
      req_ch.whole_seconds <= '0;
      req_ch.micro_seconds <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset offset
      send_request('0, 20'd0);
      send_request('0, 20'd499999);
      send_request('0, 20'd500000);
      send_request('1, 20'd500000);                 // rounds up to hour 24
      send_request(40'd86399, 20'd999999);           // rounds up to hour 24
      send_request(40'd86399, 20'hFFFFF);            // fraction saturates
      send_request(40'd12345, 20'd1000000);          // just over the fraction range
      send_request({1'b0, {(WS_W-1){1'b1}}}, 20'd0);
      send_request({1'b1, {(WS_W-1){1'b0}}}, 20'd0);
      send_request('1, 20'd0);
      // Julian to Gregorian switch
      send_request(ws_for(2299161 * DAY_SECONDS), 20'd0);
      send_request(ws_for(2299161 * DAY_SECONDS - 1), 20'd999999);
      // BC boundary
      send_request(ws_for(1721424 * DAY_SECONDS), 20'd0);
      send_request(ws_for(1721424 * DAY_SECONDS - 1), 20'd700000);
      // Starts of the skipped leap day counts
      for (int k = 3; k <= 5; k++) begin
         send_request(ws_for(key_day(k) * DAY_SECONDS), 20'd0);
         send_request(ws_for(key_day(k) * DAY_SECONDS - 1), 20'd500000);
      end
      send_request(40'd951825600, 20'd0);            // leap day 2000-02-29
      send_request(ws_for(0), 20'd0);
      send_request(ws_for(-1), 20'd0);
      repeat (265) send_random();

      // Further offsets: zero, the largest, a random one, back to reset value
      for (int phase = 1; phase <= 4; phase++) begin
         case (phase)
            1:       next_offset = '0;
            2:       next_offset = '1;
            3:       next_offset = OFF_W'({$urandom, $urandom});
            default: next_offset = EPOCH_RESET;
         endcase
         drain();
         write_offset(next_offset);
         repeat (265) send_random();
      end

      drain();
      if (fail_count == 0) begin
         $display("[seconds_to_calendar_date] OK");
      end else begin
         $display("[seconds_to_calendar_date] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/s2cd_pkg.sv
design/s2cd_req_if.sv
design/s2cd_rsp_if.sv
design/s2cd_pipe_ctrl.sv
design/seconds_to_calendar_date.sv
sim/calendar_checker.sv
sim/seconds_to_calendar_date_test.sv
